// ===== rtl/i2c_register_access_master_top_defines.svh =====
// Assertion macros for the register access master
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define RAM_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication into the next clock edge
`define RAM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== rtl/i2cram_pkg.sv =====
`timescale 1ns / 1ps

package i2cram_pkg;

    localparam int unsigned InWidth  = 35;
    localparam int unsigned InBytes  = 40;
    localparam int unsigned OutWidth = 16;
    localparam int unsigned QueueDepth = 2;
    localparam logic [7:0] TimeoutReset = 8'd100;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3,
        PH_TX0, PH_TX1, PH_TX2, PH_TX3,
        PH_AK0, PH_AK1, PH_AKP, PH_AKL,
        PH_RX0, PH_RX1, PH_RX2, PH_RX3,
        PH_MK0, PH_MK1, PH_MK2, PH_MK3,
        PH_P0, PH_P1, PH_P2
    } phase_t;

    typedef enum logic [2:0] {
        STG_DEV, STG_REG, STG_DEVRD, STG_WDATA, STG_RDATA, STG_TIMEOUT, STG_OK
    } stage_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic       is_cmd;
        logic       is_rd;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_write_byte;
        logic       done_res;
        logic       status;
        logic       busy_res;
    } result_t;

endpackage

// ===== rtl/i2c_register_access_master_top.sv =====
`timescale 1ns / 1ps
// I2C register access master.
// Slave channel s_axis_*: one beat per command or quarter-bit bus tick.
//   opcode 0 = bus tick, 1 = write transaction, 2 = read transaction.
// Master channel m_axis_*: exactly one result beat per input beat, in order,
//   carrying the driven SCL/SDA levels, SDA drive enable and status flags.
// cfg_we/cfg_wdata write ack_timeout_limit (reset value 100); write only
//   while the block is idle.
// Throughput: one beat per cycle while the receiver is ready.
// An accepted input beat passes through a two-entry queue after the
//   classifier and then one output register before its result is offered.
// Reset returns the sequencer to idle with all lines high and driven and
//   empties the queue and output register.
// When the receiver stalls, the output register holds its beat, the
//   sequencer halts, and the queue fills before s_axis_tready falls.
module i2c_register_access_master_top
    import i2cram_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // opcode[1:0] device_address[9:2] register_address[17:10]
    // byte_count[25:18] write_data[33:26] sda_sample[34], zero above
    input  logic [InBytes-1:0]   s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // scl_level[0] sda_level[1] sda_drive[2] read_byte[10:3] read_valid[11]
    // need_write_byte[12] done_res[13] status[14] busy_res[15]
    output logic [OutWidth-1:0]  m_axis_tdata
);

    logic [7:0] limit_reg;
    logic q_valid, q_ready;
    item_t q_item;
    result_t res;

    // Hold the timeout limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) limit_reg <= TimeoutReset;
        else if (cfg_we) limit_reg <= cfg_wdata;
    end

    i2cram_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    i2cram_back u_back (
        .clk(clk), .rst_n(rst_n), .timeout_limit(limit_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {res.busy_res, res.status, res.done_res, res.need_write_byte,
                           res.read_valid, res.read_byte, res.sda_drive, res.sda_level,
                           res.scl_level};

endmodule

// ===== rtl/i2cram_front.sv =====
`timescale 1ns / 1ps

module i2cram_front
    import i2cram_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [InBytes-1:0]  in_data,
    output logic                q_valid,
    input  logic                q_ready,
    output item_t               q_item
);

    item_t entry_reg [QueueDepth];
    logic  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t cls;
    opcode_t op;
    logic push, pop;

    // Classify the incoming beat
    always_comb
    begin
        op = opcode_t'(in_data[1:0]);
        cls.is_tick = (op == OP_TICK);
        cls.is_cmd = (op == OP_WRITE) || (op == OP_READ);
        cls.is_rd = (op == OP_READ);
        cls.device_address = in_data[9:2];
        cls.register_address = in_data[17:10];
        cls.byte_count = in_data[25:18];
        cls.write_data = in_data[33:26];
        cls.sda_sample = in_data[34];
    end

    assign in_ready = (count_reg != 2'(QueueDepth));
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/i2cram_back.sv =====
`timescale 1ns / 1ps

module i2cram_back
    import i2cram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  timeout_limit,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

    phase_t phase_reg, phase_next;
    stage_t stage_reg, stage_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next, left_reg, left_next, poll_reg, poll_next;
    logic [7:0] dev_reg, dev_next, regaddr_reg, regaddr_next;
    logic rd_reg, rd_next;
    logic scl_reg, scl_next, sda_reg, sda_next, drv_reg, drv_next;
    logic [7:0] rb;
    logic rv, nw, dn, st;
    logic ovalid_reg;
    result_t res_reg, res;
    logic step, adv;
    logic [7:0] tx_byte;

    assign q_ready = !ovalid_reg || out_ready;
    assign step = q_valid && q_ready;
    assign adv = step && (phase_reg != PH_IDLE) && q_item.is_tick;
    assign out_valid = ovalid_reg;
    assign out_res = res_reg;

    // Next state of the bus sequencer
    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        bit_next = bit_reg;
        shift_next = shift_reg;
        left_next = left_reg;
        poll_next = poll_reg;
        dev_next = dev_reg;
        regaddr_next = regaddr_reg;
        rd_next = rd_reg;
        nw = 1'b0;
        tx_byte = shift_reg;
        if (step && phase_reg == PH_IDLE && q_item.is_cmd)
        begin
            dev_next = q_item.device_address;
            regaddr_next = q_item.register_address;
            left_next = q_item.byte_count;
            rd_next = q_item.is_rd;
            stage_next = STG_DEV;
            bit_next = 3'd0;
            shift_next = 8'd0;
            poll_next = 8'd0;
            phase_next = PH_S0;
        end
        else if (adv)
        begin
            unique case (phase_reg)
                PH_S0: phase_next = PH_S1;
                PH_S1: phase_next = PH_S2;
                PH_S2: phase_next = PH_S3;
                PH_S3:
                begin
                    bit_next = 3'd7;
                    phase_next = PH_TX0;
                end
                PH_TX0:
                begin
                    if (bit_reg == 3'd7)
                    begin
                        case (stage_reg)
                            STG_DEV: tx_byte = dev_reg;
                            STG_REG: tx_byte = regaddr_reg;
                            STG_DEVRD: tx_byte = dev_reg + 8'd1;
                            STG_WDATA:
                            begin
                                tx_byte = q_item.write_data;
                                if (left_reg != 8'd0) left_next = left_reg - 8'd1;
                            end
                            default: tx_byte = shift_reg;
                        endcase
                    end
                    shift_next = tx_byte;
                    phase_next = PH_TX1;
                end
                PH_TX1: phase_next = PH_TX2;
                PH_TX2: phase_next = PH_TX3;
                PH_TX3:
                begin
                    if (bit_reg == 3'd0)
                    begin
                        poll_next = 8'd0;
                        phase_next = PH_AK0;
                    end
                    else
                    begin
                        bit_next = bit_reg - 3'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_TX0;
                    end
                end
                PH_AK0: phase_next = PH_AK1;
                PH_AK1: phase_next = PH_AKP;
                PH_AKP:
                begin
                    if (!q_item.sda_sample) phase_next = PH_AKL;
                    else if (poll_reg >= timeout_limit)
                    begin
                        stage_next = STG_TIMEOUT;
                        phase_next = PH_P0;
                    end
                    else poll_next = poll_reg + 8'd1;
                end
                PH_AKL:
                begin
                    case (stage_reg)
                        STG_DEV:
                        begin
                            stage_next = STG_REG;
                            bit_next = 3'd7;
                            phase_next = PH_TX0;
                        end
                        STG_REG:
                        begin
                            if (rd_reg)
                            begin
                                stage_next = STG_DEVRD;
                                phase_next = PH_S0;
                            end
                            else if (left_reg != 8'd0)
                            begin
                                stage_next = STG_WDATA;
                                nw = 1'b1;
                                bit_next = 3'd7;
                                phase_next = PH_TX0;
                            end
                            else
                            begin
                                stage_next = STG_OK;
                                phase_next = PH_P0;
                            end
                        end
                        STG_DEVRD:
                        begin
                            if (left_reg != 8'd0)
                            begin
                                stage_next = STG_RDATA;
                                bit_next = 3'd7;
                                shift_next = 8'd0;
                                phase_next = PH_RX0;
                            end
                            else
                            begin
                                stage_next = STG_OK;
                                phase_next = PH_P0;
                            end
                        end
                        STG_WDATA:
                        begin
                            if (left_reg != 8'd0)
                            begin
                                nw = 1'b1;
                                bit_next = 3'd7;
                                phase_next = PH_TX0;
                            end
                            else
                            begin
                                stage_next = STG_OK;
                                phase_next = PH_P0;
                            end
                        end
                        default:
                        begin
                            stage_next = STG_OK;
                            phase_next = PH_P0;
                        end
                    endcase
                end
                PH_RX0: phase_next = PH_RX1;
                PH_RX1: phase_next = PH_RX2;
                PH_RX2:
                begin
                    shift_next = {shift_reg[6:0], q_item.sda_sample};
                    if (bit_reg == 3'd0 && left_reg != 8'd0) left_next = left_reg - 8'd1;
                    phase_next = PH_RX3;
                end
                PH_RX3:
                begin
                    if (bit_reg == 3'd0) phase_next = PH_MK0;
                    else
                    begin
                        bit_next = bit_reg - 3'd1;
                        phase_next = PH_RX0;
                    end
                end
                PH_MK0: phase_next = PH_MK1;
                PH_MK1: phase_next = PH_MK2;
                PH_MK2: phase_next = PH_MK3;
                PH_MK3:
                begin
                    if (left_reg != 8'd0)
                    begin
                        bit_next = 3'd7;
                        shift_next = 8'd0;
                        phase_next = PH_RX0;
                    end
                    else
                    begin
                        stage_next = STG_OK;
                        phase_next = PH_P0;
                    end
                end
                PH_P0: phase_next = PH_P1;
                PH_P1: phase_next = PH_P2;
                PH_P2:
                begin
                    stage_next = STG_DEV;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    stage_next = STG_DEV;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Line levels and flags for this beat
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        drv_next = drv_reg;
        rb = 8'd0;
        rv = 1'b0;
        dn = 1'b0;
        st = 1'b0;
        if (adv)
        begin
            unique case (phase_reg)
                PH_S0: {scl_next, sda_next, drv_next} = {stage_reg == STG_DEV, 2'b11};
                PH_S1: {scl_next, sda_next, drv_next} = 3'b111;
                PH_S2: {scl_next, sda_next, drv_next} = 3'b101;
                PH_S3: {scl_next, sda_next, drv_next} = 3'b001;
                PH_TX0: {scl_next, sda_next, drv_next} = {1'b0, tx_byte[7], 1'b1};
                PH_TX1, PH_TX2: {scl_next, drv_next} = 2'b11;
                PH_TX3: {scl_next, drv_next} = 2'b01;
                PH_AK0, PH_AKL, PH_RX0, PH_RX3:
                    {scl_next, sda_next, drv_next} = 3'b010;
                PH_AK1, PH_AKP, PH_RX1: {scl_next, sda_next, drv_next} = 3'b110;
                PH_RX2:
                begin
                    {scl_next, sda_next, drv_next} = 3'b110;
                    if (bit_reg == 3'd0)
                    begin
                        rb = {shift_reg[6:0], q_item.sda_sample};
                        rv = 1'b1;
                    end
                end
                PH_MK0: {scl_next, sda_next, drv_next} = {1'b0, left_reg == 8'd0, 1'b1};
                PH_MK1, PH_MK2: {scl_next, drv_next} = 2'b11;
                PH_MK3: {scl_next, drv_next} = 2'b01;
                PH_P0: {scl_next, sda_next, drv_next} = 3'b001;
                PH_P1: {scl_next, sda_next, drv_next} = 3'b101;
                PH_P2:
                begin
                    {scl_next, sda_next, drv_next} = 3'b111;
                    dn = 1'b1;
                    st = (stage_reg == STG_TIMEOUT);
                end
                default: {scl_next, sda_next, drv_next} = 3'b111;
            endcase
        end
        res.scl_level = scl_next;
        res.sda_level = sda_next;
        res.sda_drive = drv_next;
        res.read_byte = rb;
        res.read_valid = rv;
        res.need_write_byte = nw;
        res.done_res = dn;
        res.status = st;
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            stage_reg <= STG_DEV;
            bit_reg <= 3'd0;
            shift_reg <= 8'd0;
            left_reg <= 8'd0;
            poll_reg <= 8'd0;
            dev_reg <= 8'd0;
            regaddr_reg <= 8'd0;
            rd_reg <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            drv_reg <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            bit_reg <= bit_next;
            shift_reg <= shift_next;
            left_reg <= left_next;
            poll_reg <= poll_next;
            dev_reg <= dev_next;
            regaddr_reg <= regaddr_next;
            rd_reg <= rd_next;
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            drv_reg <= drv_next;
            if (step) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/i2cram_checker.sv =====
`timescale 1ns / 1ps
`include "i2c_register_access_master_top_defines.svh"

module i2cram_checker
    import i2cram_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutWidth-1:0] m_axis_tdata
);

    logic beat;
    assign beat = m_axis_tvalid && m_axis_tready;

    // Status only reported on the done beat
    `RAM_ASSERT_IMP(a_status_done, clk, rst_n, beat && m_axis_tdata[14], m_axis_tdata[13], "status without done")
    // Done ends the transaction
    `RAM_ASSERT_IMP(a_done_idle, clk, rst_n, beat && m_axis_tdata[13], !m_axis_tdata[15], "busy after done")
    // A read byte is taken with SCL high and SDA released
    `RAM_ASSERT_IMP(a_rd_lines, clk, rst_n, beat && m_axis_tdata[11], m_axis_tdata[0] && !m_axis_tdata[2], "read byte on bad lines")
    // A stalled beat holds
    `RAM_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind i2c_register_access_master_top i2cram_checker u_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== tb/i2c_register_access_master_checker.sv =====
`timescale 1ns / 1ps

module i2c_register_access_master_checker
    import i2cram_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [InBytes-1:0]  s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OutWidth-1:0] m_axis_tdata,
    output int                  fail_count,
    output int                  beats_pending
);

    // Shadow sequencer state
    phase_t     phase;
    stage_t     stage;
    logic [2:0] bit_idx;
    logic [7:0] shifter;
    logic [7:0] bytes_left;
    logic [7:0] polls;
    logic [7:0] dev_byte;
    logic [7:0] reg_byte;
    logic       rd_txn;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    logic [7:0] ack_limit;

    logic [OutWidth-1:0] line_beats_q[$];

    task automatic set_lines(input logic c, input logic d, input logic e);
        scl_q = c;
        sda_q = d;
        drv_q = e;
    endtask

    task automatic start_byte();
        bit_idx = 3'd7;
        phase   = PH_TX0;
    endtask

    task automatic start_stop(input stage_t s);
        stage = s;
        phase = PH_P0;
    endtask

    // Decide what follows an acknowledged byte
    task automatic next_after_ack(inout logic nw);
        case (stage)
            STG_DEV:
            begin
                stage = STG_REG;
                start_byte();
            end
            STG_REG:
            begin
                if (rd_txn)
                begin
                    stage = STG_DEVRD;
                    phase = PH_S0;
                end
                else if (bytes_left > 0)
                begin
                    stage = STG_WDATA;
                    nw = 1'b1;
                    start_byte();
                end
                else
                    start_stop(STG_OK);
            end
            STG_DEVRD:
            begin
                if (bytes_left > 0)
                begin
                    stage   = STG_RDATA;
                    bit_idx = 3'd7;
                    shifter = 8'd0;
                    phase   = PH_RX0;
                end
                else
                    start_stop(STG_OK);
            end
            STG_WDATA:
            begin
                if (bytes_left > 0)
                begin
                    nw = 1'b1;
                    start_byte();
                end
                else
                    start_stop(STG_OK);
            end
            default: start_stop(STG_OK);
        endcase
    endtask

    // Advance the bus by one quarter-bit tick
    task automatic bus_tick(input logic sda_in, input logic [7:0] wd,
                            inout logic [7:0] rb, inout logic rv, inout logic nw,
                            inout logic dn, inout logic st);
        case (phase)
            PH_S0:
            begin
                set_lines(stage == STG_DEV, 1'b1, 1'b1);
                phase = PH_S1;
            end
            PH_S1:
            begin
                set_lines(1'b1, 1'b1, 1'b1);
                phase = PH_S2;
            end
            PH_S2:
            begin
                set_lines(1'b1, 1'b0, 1'b1);
                phase = PH_S3;
            end
            PH_S3:
            begin
                set_lines(1'b0, 1'b0, 1'b1);
                start_byte();
            end
            PH_TX0:
            begin
                if (bit_idx == 3'd7)
                begin
                    if (stage == STG_DEV)
                        shifter = dev_byte;
                    else if (stage == STG_REG)
                        shifter = reg_byte;
                    else if (stage == STG_DEVRD)
                        shifter = dev_byte + 8'd1;
                    else if (stage == STG_WDATA)
                    begin
                        shifter = wd;
                        if (bytes_left > 0)
                            bytes_left = bytes_left - 8'd1;
                    end
                end
                set_lines(1'b0, shifter[7], 1'b1);
                phase = PH_TX1;
            end
            PH_TX1:
            begin
                set_lines(1'b1, sda_q, 1'b1);
                phase = PH_TX2;
            end
            PH_TX2:
            begin
                set_lines(1'b1, sda_q, 1'b1);
                phase = PH_TX3;
            end
            PH_TX3:
            begin
                set_lines(1'b0, sda_q, 1'b1);
                if (bit_idx == 3'd0)
                begin
                    polls = 8'd0;
                    phase = PH_AK0;
                end
                else
                begin
                    bit_idx = bit_idx - 3'd1;
                    shifter = shifter << 1;
                    phase   = PH_TX0;
                end
            end
            PH_AK0:
            begin
                set_lines(1'b0, 1'b1, 1'b0);
                phase = PH_AK1;
            end
            PH_AK1:
            begin
                set_lines(1'b1, 1'b1, 1'b0);
                phase = PH_AKP;
            end
            PH_AKP:
            begin
                set_lines(1'b1, 1'b1, 1'b0);
                if (!sda_in)
                    phase = PH_AKL;
                else if (polls >= ack_limit)
                    start_stop(STG_TIMEOUT);
                else
                    polls = polls + 8'd1;
            end
            PH_AKL:
            begin
                set_lines(1'b0, 1'b1, 1'b0);
                next_after_ack(nw);
            end
            PH_RX0:
            begin
                set_lines(1'b0, 1'b1, 1'b0);
                phase = PH_RX1;
            end
            PH_RX1:
            begin
                set_lines(1'b1, 1'b1, 1'b0);
                phase = PH_RX2;
            end
            PH_RX2:
            begin
                set_lines(1'b1, 1'b1, 1'b0);
                shifter = {shifter[6:0], sda_in};
                if (bit_idx == 3'd0)
                begin
                    rb = shifter;
                    rv = 1'b1;
                    if (bytes_left > 0)
                        bytes_left = bytes_left - 8'd1;
                end
                phase = PH_RX3;
            end
            PH_RX3:
            begin
                set_lines(1'b0, 1'b1, 1'b0);
                if (bit_idx == 3'd0)
                    phase = PH_MK0;
                else
                begin
                    bit_idx = bit_idx - 3'd1;
                    phase   = PH_RX0;
                end
            end
            PH_MK0:
            begin
                set_lines(1'b0, bytes_left == 0, 1'b1);
                phase = PH_MK1;
            end
            PH_MK1:
            begin
                set_lines(1'b1, sda_q, 1'b1);
                phase = PH_MK2;
            end
            PH_MK2:
            begin
                set_lines(1'b1, sda_q, 1'b1);
                phase = PH_MK3;
            end
            PH_MK3:
            begin
                set_lines(1'b0, sda_q, 1'b1);
                if (bytes_left > 0)
                begin
                    bit_idx = 3'd7;
                    shifter = 8'd0;
                    phase   = PH_RX0;
                end
                else
                    start_stop(STG_OK);
            end
            PH_P0:
            begin
                set_lines(1'b0, 1'b0, 1'b1);
                phase = PH_P1;
            end
            PH_P1:
            begin
                set_lines(1'b1, 1'b0, 1'b1);
                phase = PH_P2;
            end
            PH_P2:
            begin
                set_lines(1'b1, 1'b1, 1'b1);
                dn    = 1'b1;
                st    = (stage == STG_TIMEOUT);
                stage = STG_DEV;
                phase = PH_IDLE;
            end
            default:
            begin
                set_lines(1'b1, 1'b1, 1'b1);
                stage = STG_DEV;
                phase = PH_IDLE;
            end
        endcase
    endtask

    // Work out the line levels and flags that one input beat produces
    task automatic predict_lines(input logic [InBytes-1:0] beat,
                                 output logic [OutWidth-1:0] res);
        opcode_t    op;
        logic [7:0] rb;
        logic       rv;
        logic       nw;
        logic       dn;
        logic       st;
        op = opcode_t'(beat[1:0]);
        rb = 8'd0;
        rv = 1'b0;
        nw = 1'b0;
        dn = 1'b0;
        st = 1'b0;
        if (phase == PH_IDLE)
        begin
            if (op == OP_WRITE || op == OP_READ)
            begin
                dev_byte   = beat[9:2];
                reg_byte   = beat[17:10];
                bytes_left = beat[25:18];
                rd_txn     = (op == OP_READ);
                stage      = STG_DEV;
                bit_idx    = 3'd0;
                shifter    = 8'd0;
                polls      = 8'd0;
                phase      = PH_S0;
            end
        end
        else if (op == OP_TICK)
            bus_tick(beat[34], beat[33:26], rb, rv, nw, dn, st);
        res = {phase != PH_IDLE, st, dn, nw, rv, rb, drv_q, sda_q, scl_q};
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name,
                     want, got);
            fail_count++;
        end
    endtask

    logic [OutWidth-1:0] want_beat;

    // Predict on accepted inputs, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase      = PH_IDLE;
            stage      = STG_DEV;
            bit_idx    = 3'd0;
            shifter    = 8'd0;
            bytes_left = 8'd0;
            polls      = 8'd0;
            dev_byte   = 8'd0;
            reg_byte   = 8'd0;
            rd_txn     = 1'b0;
            ack_limit  = TimeoutReset;
            set_lines(1'b1, 1'b1, 1'b1);
            line_beats_q.delete();
            fail_count    = 0;
            beats_pending = 0;
        end
        else
        begin
            if (cfg_we)
                ack_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_lines(s_axis_tdata, want_beat);
                line_beats_q.push_back(want_beat);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (line_beats_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0h",
                             $realtime, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want_beat = line_beats_q.pop_front();
                    check_field("scl_level", want_beat[0], m_axis_tdata[0]);
                    check_field("sda_level", want_beat[1], m_axis_tdata[1]);
                    check_field("sda_drive", want_beat[2], m_axis_tdata[2]);
                    check_field("read_byte", want_beat[10:3], m_axis_tdata[10:3]);
                    check_field("read_valid", want_beat[11], m_axis_tdata[11]);
                    check_field("need_write_byte", want_beat[12], m_axis_tdata[12]);
                    check_field("done_res", want_beat[13], m_axis_tdata[13]);
                    check_field("status", want_beat[14], m_axis_tdata[14]);
                    check_field("busy_res", want_beat[15], m_axis_tdata[15]);
                end
            end
            beats_pending = line_beats_q.size();
        end
    end

endmodule

// ===== tb/tb_i2c_register_access_master_top.sv =====
`timescale 1ns / 1ps

module tb_i2c_register_access_master_top;
    import i2cram_pkg::*;

    localparam int CycleLimit = 200000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [7:0]          cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InBytes-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutWidth-1:0] m_axis_tdata;

    int fail_count;
    int beats_pending;
    int send_idle_pct;
    int stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int cycles;

    i2c_register_access_master_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2c_register_access_master_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .beats_pending (beats_pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Receiver: random stalls, plus a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = 80;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one beat, idling first at the current rate
    task automatic send_beat(input opcode_t op, input logic [7:0] dev,
                             input logic [7:0] ra, input logic [7:0] cnt,
                             input logic [7:0] wd, input logic sda);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, sda, wd, cnt, ra, dev, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Mostly bus ticks, with commands and stray opcodes mixed in
    task automatic send_random();
        int      pick;
        opcode_t op;
        logic [7:0] cnt;
        pick = $urandom_range(99);
        if (pick < 84)
            op = OP_TICK;
        else if (pick < 91)
            op = OP_WRITE;
        else if (pick < 98)
            op = OP_READ;
        else
            op = OP_NONE;
        cnt = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 4))
                                        : 8'($urandom_range(3));
        send_beat(op, 8'($urandom), 8'($urandom), cnt, 8'($urandom),
                  $urandom_range(99) < 40);
    endtask

    // Drain all results, then let the pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (beats_pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    int limits[5];

    initial
    begin
        cycles        = 0;
        hold_reqs     = 0;
        hold_seen     = 0;
        hold_left     = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Idle ticks and a stray opcode do nothing
        send_beat(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_beat(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // No acknowledge tolerated: a full-count write times out at once
        write_limit(8'd0);
        send_beat(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_beat(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat (45) send_beat(OP_TICK, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        // Read of zero bytes at the top device address wraps to zero
        write_limit(8'd255);
        send_beat(OP_READ, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_beat(OP_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat (140) send_beat(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);

        limits = '{100, 3, 0, 255, 1};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(ph == 4 ? 8'($urandom) : 8'(limits[ph]));
            case (ph)
                1: begin send_idle_pct = 50; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 50; end
                3: begin send_idle_pct = 33; stall_pct = 33; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 260; n++)
            begin
                if (ph == 0 && n == 100)
                    hold_reqs++;
                if (ph == 3 && n == 130)
                    wait_drained();
                send_random();
            end
        end
        wait_drained();
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/i2cram_pkg.sv
rtl/i2cram_front.sv
rtl/i2cram_back.sv
rtl/i2c_register_access_master_top.sv
rtl/i2cram_checker.sv
tb/i2c_register_access_master_checker.sv
tb/tb_i2c_register_access_master_top.sv
